FILE: hw/rtl/bds_pkg.sv
package bds_pkg;

    localparam int unsigned BaudW   = 31;
    localparam int unsigned OscW    = 32;
    localparam int unsigned DvdW    = 30;  // widest prescaled clock
    localparam int unsigned CandW   = 16;
    localparam int unsigned Lanes   = 2;   // lane 0: shift by 4, lane 1: shift by 2
    localparam int unsigned Steps   = DvdW;
    localparam logic [OscW-1:0] OscReset = 32'd1000000;

    typedef struct packed {
        logic [BaudW-1:0] rem;
        logic [DvdW-1:0]  dvd;
        logic [DvdW-1:0]  quo;
        logic [BaudW-1:0] dsr;
    } div_lane_t;

    typedef struct packed {
        logic [BaudW-1:0] baud;
        logic [CandW-1:0] cand_slow;
        logic [CandW-1:0] cand_fast;
    } div_tag_t;

    typedef struct packed {
        logic                   valid;
        div_tag_t               tag;
        div_lane_t [Lanes-1:0]  lane;
    } div_stage_t;

    function automatic div_lane_t lane_start(input logic [DvdW-1:0] dvd,
                                             input logic [BaudW-1:0] dsr);
        div_lane_t l;
        l.rem = '0;
        l.dvd = dvd;
        l.quo = '0;
        l.dsr = dsr;
        return l;
    endfunction

endpackage

FILE: hw/rtl/baud_divisor_search.sv
// Baud divisor search.
// Input stream s_*: one wanted baud rate per transfer. Output stream m_*:
// one divisor (tdata) and high-speed flag (tuser) per input, in order.
// cfg_we/cfg_wdata write the oscillator frequency; write only while idle.
// Two chains of 30 restoring-division cells: the first divides both
// prescaled clocks by the baud rate, the second divides them by the
// resulting candidates. A final stage scores both candidates and loads
// the output register.
// Throughput: one transfer per cycle when not stalled; every cell takes a new item each
// cycle the pipeline advances.
// Reset clears all valid bits and loads 1000000 Hz into the frequency
// register. When the receiver stalls with a result waiting, the whole
// pipeline holds and s_tready drops until that result is taken.
module baud_divisor_search
    import bds_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [31:0] cfg_wdata,     // osc_frequency
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,       // [30:0] baud_rate, [31] zero
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,       // [15:0] divisor
    output logic        m_tuser        // [0] high_speed
);

    logic [OscW-1:0] osc_reg;
    logic            en;
    logic            out_valid;

    div_stage_t head1, head2;
    div_stage_t chain1 [Steps+1];
    div_stage_t chain2 [Steps+1];
    logic [BaudW-1:0] baud_in;
    logic [DvdW-1:0]  clk_slow, clk_fast;
    logic [CandW-1:0] c_slow, c_fast;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            osc_reg <= OscReset;
        end else if (cfg_we) begin
            osc_reg <= cfg_wdata;
        end
    end

    // advance everything unless a result is waiting and not taken
    assign en       = !out_valid || m_tready;
    assign s_tready = en;
    assign m_tvalid = out_valid;

    assign baud_in  = s_tdata[BaudW-1:0];
    assign clk_slow = DvdW'(osc_reg >> 4);
    assign clk_fast = DvdW'(osc_reg >> 2);

    always_comb begin
        head1.valid         = s_tvalid;
        head1.tag.baud      = baud_in;
        head1.tag.cand_slow = '0;
        head1.tag.cand_fast = '0;
        head1.lane[0]       = lane_start(clk_slow, baud_in);
        head1.lane[1]       = lane_start(clk_fast, baud_in);
    end

    assign chain1[0] = head1;

    for (genvar g = 0; g < Steps; g++) begin : g_div1
        bds_div_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .en        (en),
            .stage_in  (chain1[g]),
            .stage_out (chain1[g+1])
        );
    end

    // truncate quotients to candidates; a zero baud rate gives no candidate
    always_comb begin
        c_slow = (chain1[Steps].tag.baud != '0) ? chain1[Steps].lane[0].quo[CandW-1:0] : '0;
        c_fast = (chain1[Steps].tag.baud != '0) ? chain1[Steps].lane[1].quo[CandW-1:0] : '0;
        head2.valid         = chain1[Steps].valid;
        head2.tag.baud      = chain1[Steps].tag.baud;
        head2.tag.cand_slow = c_slow;
        head2.tag.cand_fast = c_fast;
        head2.lane[0]       = lane_start(clk_slow, BaudW'(c_slow));
        head2.lane[1]       = lane_start(clk_fast, BaudW'(c_fast));
    end

    assign chain2[0] = head2;

    for (genvar g = 0; g < Steps; g++) begin : g_div2
        bds_div_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .en        (en),
            .stage_in  (chain2[g]),
            .stage_out (chain2[g+1])
        );
    end

    bds_pick u_pick (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .en          (en),
        .stage_in    (chain2[Steps]),
        .out_valid   (out_valid),
        .out_divisor (m_tdata),
        .out_fast    (m_tuser)
    );

endmodule

FILE: hw/rtl/bds_div_cell.sv
module bds_div_cell
    import bds_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       en,
    input  div_stage_t stage_in,
    output div_stage_t stage_out
);

    logic       valid_reg;
    div_stage_t data_reg;
    div_stage_t data_next;
    logic [BaudW:0] trial [Lanes];

    // one restoring division step per lane: bring down the next dividend bit
    always_comb begin
        data_next = stage_in;
        for (int i = 0; i < Lanes; i++) begin
            trial[i] = {stage_in.lane[i].rem, stage_in.lane[i].dvd[DvdW-1]};
            data_next.lane[i].dvd = {stage_in.lane[i].dvd[DvdW-2:0], 1'b0};
            if (trial[i] >= {1'b0, stage_in.lane[i].dsr}) begin
                data_next.lane[i].rem =
                    BaudW'(trial[i] - {1'b0, stage_in.lane[i].dsr});
                data_next.lane[i].quo = {stage_in.lane[i].quo[DvdW-2:0], 1'b1};
            end else begin
                data_next.lane[i].rem = trial[i][BaudW-1:0];
                data_next.lane[i].quo = {stage_in.lane[i].quo[DvdW-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= stage_in.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            data_reg <= data_next;
        end
    end

    always_comb begin
        stage_out       = data_reg;
        stage_out.valid = valid_reg;
    end

endmodule

FILE: hw/rtl/bds_pick.sv
module bds_pick
    import bds_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             en,
    input  div_stage_t       stage_in,
    output logic             out_valid,
    output logic [CandW-1:0] out_divisor,
    output logic             out_fast
);

    logic             valid_reg;
    logic [CandW-1:0] divisor_reg, divisor_next;
    logic             fast_reg, fast_next;

    logic [BaudW:0]   e_slow, e_fast, err1, err2, best1;
    logic [BaudW:0]   baud_x, q_slow, q_fast;
    logic             win_slow, win_fast;
    logic [CandW-1:0] choice1, choice2;

    always_comb begin
        baud_x = {1'b0, stage_in.tag.baud};
        q_slow = (BaudW+1)'(stage_in.lane[0].quo);
        q_fast = (BaudW+1)'(stage_in.lane[1].quo);
        e_slow = (baud_x >= q_slow) ? baud_x - q_slow : q_slow - baud_x;
        e_fast = (baud_x >= q_fast) ? baud_x - q_fast : q_fast - baud_x;

        // a zero candidate keeps the previous error, which starts at zero
        err1     = (stage_in.tag.cand_slow != '0) ? e_slow : '0;
        win_slow = err1 < baud_x;
        best1    = win_slow ? err1 : baud_x;
        choice1  = win_slow ? stage_in.tag.cand_slow : '0;

        err2     = (stage_in.tag.cand_fast != '0) ? e_fast : err1;
        win_fast = err2 < best1;
        choice2  = win_fast ? stage_in.tag.cand_fast : choice1;

        divisor_next = choice2 - CandW'(1);
        fast_next    = win_fast;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= stage_in.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            divisor_reg <= divisor_next;
            fast_reg    <= fast_next;
        end
    end

    assign out_valid   = valid_reg;
    assign out_divisor = divisor_reg;
    assign out_fast    = fast_reg;

endmodule

FILE: verif/tb_top.sv
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import bds_pkg::*;

    typedef struct {
        logic [15:0] divisor;
        logic        high_speed;
    } baud_choice_t;

    // Predicts one divisor choice per baud request and checks results in order.
    class divisor_board;
        baud_choice_t pending[$];
        int           errors;
        logic [31:0]  osc_hz;

        function new();
            errors = 0;
            osc_hz = OscReset;
        endfunction

        function baud_choice_t pick(logic [30:0] baud);
            baud_choice_t r;
            longint       err, best, d;
            logic [31:0]  clk, q;
            logic [15:0]  cand, choice;
            int           sh;
            err = 0;
            best = baud;
            choice = '0;
            r.high_speed = 1'b0;
            for (int i = 0; i < 2; i++) begin
                sh = (i == 0) ? 4 : 2;
                clk = osc_hz >> sh;
                cand = '0;
                if (baud != 0) begin
                    q = clk / {1'b0, baud};
                    cand = q[15:0];
                end
                if (cand != 0) begin
                    d = longint'(baud) - longint'(clk / {16'd0, cand});
                    err = (d < 0) ? -d : d;
                end
                if (err < best) begin
                    best = err;
                    choice = cand;
                    r.high_speed = (i == 1);
                end
            end
            r.divisor = choice - 16'd1;
            return r;
        endfunction

        function void note_request(logic [30:0] baud);
            pending.push_back(pick(baud));
        endfunction

        function void check_result(logic [15:0] dv, logic hs);
            baud_choice_t e;
            if (pending.size() == 0) begin
                $error("result with nothing pending: divisor %0d", dv);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (e.divisor !== dv) begin
                $error("divisor: expected %0d actual %0d", e.divisor, dv);
                errors++;
            end
            if (e.high_speed !== hs) begin
                $error("high_speed: expected %0d actual %0d", e.high_speed, hs);
                errors++;
            end
        endfunction
    endclass

    logic        aclk = 0;
    logic        aresetn = 0;
    logic        cfg_we = 0;
    logic [31:0] cfg_wdata = 0;
    logic        s_tvalid = 0;
    logic        s_tready;
    logic [31:0] s_tdata = 0;
    logic        m_tvalid;
    logic        m_tready = 0;
    logic [15:0] m_tdata;
    logic        m_tuser;

    divisor_board board;
    bit          calm = 0;
    longint      cycles = 0;

    baud_divisor_search dut (.*);

    always #5 aclk = ~aclk;

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > 400000) begin
            $display("tb_top: errors");
            $finish;
        end
    end

    // Receiver: random stall bursts, none in the calm tail.
    initial begin
        int n;
        @(posedge aclk iff aresetn);
        forever begin
            if (!calm && $urandom_range(0, 3) == 0) begin
                n = $urandom_range(1, 6);
                m_tready <= 0;
                repeat (n) @(posedge aclk);
            end
            m_tready <= 1;
            @(posedge aclk);
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            board.check_result(m_tdata, m_tuser);
    end

    task automatic send_baud(logic [30:0] baud);
        if (!calm && $urandom_range(0, 4) == 0) begin
            s_tvalid <= 0;
            repeat ($urandom_range(1, 6)) @(posedge aclk);
        end
        s_tvalid <= 1;
        s_tdata <= {1'b0, baud};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        board.note_request(baud);
    endtask

    task automatic drain();
        s_tvalid <= 0;
        @(posedge aclk);
        while (board.pending.size() != 0) @(posedge aclk);
        repeat (70) @(posedge aclk);
    endtask

    task automatic set_osc(logic [31:0] hz);
        drain();
        cfg_we <= 1;
        cfg_wdata <= hz;
        @(posedge aclk);
        cfg_we <= 0;
        board.osc_hz = hz;
        @(posedge aclk);
    endtask

    function automatic logic [30:0] rand_baud(logic [31:0] hz);
        logic [31:0] t;
        case ($urandom_range(0, 4))
            0: return 31'($urandom_range(1, 1000));
            1: return 31'($urandom_range(300, 1000000));
            2: begin
                t = hz >> $urandom_range(4, 20);
                return (t == 0) ? 31'd1 : t[30:0];
            end
            3: return 31'($urandom);
            default: return (hz[30:0] == 0) ? 31'd1 : hz[30:0];
        endcase
    endfunction

    initial begin
        logic [31:0] osc_set[6];
        logic [31:0] hz;
        board = new();
        osc_set = '{32'd1, 32'hffffffff, 32'd16000000, 32'd64, 32'd48000000, 32'd1000000};
        repeat (6) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);
        // directed at reset frequency
        send_baud(31'd1);
        send_baud(31'h7fffffff);
        send_baud(31'd9600);
        send_baud(31'd62500);
        send_baud(31'd62501);
        send_baud(31'd250000);
        send_baud(31'd250001);
        send_baud(31'd15);
        set_osc(32'hffffffff);
        send_baud(31'd1);
        send_baud(31'd2);
        send_baud(31'd115200);
        send_baud(31'h7fffffff);
        send_baud(31'h55555555);
        send_baud(31'h2aaaaaaa);
        set_osc(32'd1);
        send_baud(31'd1);
        send_baud(31'd3);
        for (int p = 0; p < 6; p++) begin
            hz = (p == 3) ? {$urandom} : osc_set[p];
            set_osc(hz);
            for (int i = 0; i < 140; i++) begin
                if (p == 5 && i == 60) calm = 1;
                if (p == 2 && i == 70) drain();
                send_baud(rand_baud(hz));
            end
        end
        drain();
        if (board.errors == 0 && board.pending.size() == 0) begin
            $display("tb_top: clean");
        end else begin
            $display("tb_top: errors");
        end
        $finish;
    end
endmodule
